>>> design/keypad_code_lock_controller_top_defines.svh
// ----------------------------------------------------------------------------
// Keypad code lock controller: assertion macros
// Concurrent assertion wrappers that are active in simulation and empty in
// synthesis. They use the clk and rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked on every edge outside reset
`define KCL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define KCL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KCL_ASSERT(name, prop, msg)
`define KCL_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

>>> design/kcl_pkg.sv
// ----------------------------------------------------------------------------
// Keypad code lock controller: package
// Shared types, key codes, register indexes and the code match function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int CODE_W  = 36;
    localparam int SLOT_MAX = 4;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;
    localparam logic [3:0] KEY_STAR      = 4'd12;
    localparam logic [3:0] FAIL_SAT      = 4'd15;

    localparam logic [CODE_W-1:0] ACCESS_CODE_RST = 36'h4_0000_1234;
    localparam logic [CODE_W-1:0] ADMIN_CODE_RST  = 36'h4_0000_0403;
    localparam logic [3:0]        MAX_FAIL_RST    = 4'd3;

    typedef enum logic [2:0] {
        REG_ACCESS   = 3'd0,
        REG_ADMIN    = 3'd1,
        REG_USER0    = 3'd2,
        REG_USER1    = 3'd3,
        REG_USER2    = 3'd4,
        REG_USER3    = 3'd5,
        REG_MAX_FAIL = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ENTER  = 2'd1,
        MODE_ADMIN  = 2'd2,
        MODE_LOCKED = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_CANCELLED    = 4'd1,
        EV_DIGIT        = 4'd2,
        EV_ADMIN_PROMPT = 4'd3,
        EV_GRANTED      = 4'd4,
        EV_DENIED       = 4'd5,
        EV_LOCKED       = 4'd6,
        EV_ADMIN_OK     = 4'd7,
        EV_ADMIN_BAD    = 4'd8,
        EV_UNLOCKED     = 4'd9,
        EV_STILL_LOCKED = 4'd10
    } event_t;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_USER   = 2'd1,
        SRC_ACCESS = 2'd2
    } src_t;

    typedef struct packed {
        logic [CODE_W-1:0]               access_code;
        logic [CODE_W-1:0]               admin_code;
        logic [SLOT_MAX-1:0][CODE_W-1:0] user_code;
        logic [3:0]                      max_failures;
    } cfg_t;

    typedef struct packed {
        mode_t      mode_after;
        event_t     event_res;
        logic       unlock_pulse;
        src_t       grant_source;
        logic [1:0] matched_slot;
        logic [3:0] digits_entered;
        logic [3:0] failure_count;
    } res_t;

    // length in 35:32, right-aligned BCD digits in 31:0
    function automatic logic code_match(
        input logic [31:0]       digits,
        input logic [3:0]        len,
        input logic              ovf,
        input logic [CODE_W-1:0] code
    );
        logic [31:0] mask;
        logic [3:0]  clen;
        clen = code[35:32];
        for (int i = 0; i < 8; i++) begin
            mask[i*4 +: 4] = (4'(i) < clen) ? 4'hF : 4'h0;
        end
        return !ovf && (clen != 4'd0) && (clen == len) && ((code[31:0] & mask) == digits);
    endfunction

endpackage

>>> design/keypad_code_lock_controller_top.sv
// Path: key beat -> input key register -> result register. Throughput: one
// key per cycle; the input register and the result register both advance
// whenever the result register is empty or being taken.
// Reset (rst_n, async, active low): idle mode, empty entry, zero failures,
// default codes 1234 / 0403, failure limit 3; config writes always ready.
// ----------------------------------------------------------------------------
// Keypad code lock controller: top level
// Input key register, lock core and result handshake, plus config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_code_lock_controller_top #(
    parameter int MAX_DIGITS = 8,
    parameter int USER_SLOTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_stall,
    input  logic [3:0]  key,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  mode_after,
    output logic [3:0]  event_res,
    output logic        unlock_pulse,
    output logic [1:0]  grant_source,
    output logic [1:0]  matched_slot,
    output logic [3:0]  digits_entered,
    output logic [3:0]  failure_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data
);
    import kcl_pkg::*;

    logic       key_full_reg;
    logic       key_full_next;
    logic [3:0] key_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;
    logic       step;
    logic       key_take;
    cfg_t       cfg;
    res_t       res;

    assign cfg_ready = 1'b1;

    kcl_cfg_regs #(
        .USER_SLOTS (USER_SLOTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free  = !res_valid_reg || !res_stall;
    assign step      = key_full_reg && out_free;
    assign key_stall = key_full_reg && !out_free;
    assign key_take  = key_valid && !key_stall;

    always_comb
    begin
        key_full_next = key_full_reg;
        if (key_take)
        begin
            key_full_next = 1'b1;
        end
        else if (step)
        begin
            key_full_next = 1'b0;
        end
        res_valid_next = out_free ? step : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            key_full_reg  <= key_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_take)
        begin
            key_reg <= key;
        end
    end

    kcl_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step),
        .key     (key_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign res_valid      = res_valid_reg;
    assign mode_after     = res.mode_after;
    assign event_res      = res.event_res;
    assign unlock_pulse   = res.unlock_pulse;
    assign grant_source   = res.grant_source;
    assign matched_slot   = res.matched_slot;
    assign digits_entered = res.digits_entered;
    assign failure_count  = res.failure_count;

endmodule

>>> design/kcl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Keypad code lock controller: configuration registers
// Holds the access, admin and user codes and the failure limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcl_cfg_regs #(
    parameter int USER_SLOTS = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [35:0]              cfg_data,
    output kcl_pkg::cfg_t            cfg
);
    import kcl_pkg::*;

    logic [CODE_W-1:0]   access_reg;
    logic [CODE_W-1:0]   admin_reg;
    logic [3:0]          max_fail_reg;
    logic                we_access;
    logic                we_admin;
    logic                we_max;
    logic [SLOT_MAX-1:0] we_user;

    always_comb
    begin
        we_access = 1'b0;
        we_admin  = 1'b0;
        we_max    = 1'b0;
        we_user   = '0;
        unique case (cfg_index)
            REG_ACCESS:   we_access  = cfg_we;
            REG_ADMIN:    we_admin   = cfg_we;
            REG_USER0:    we_user[0] = cfg_we;
            REG_USER1:    we_user[1] = cfg_we;
            REG_USER2:    we_user[2] = cfg_we;
            REG_USER3:    we_user[3] = cfg_we;
            REG_MAX_FAIL: we_max     = cfg_we;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg   <= ACCESS_CODE_RST;
            admin_reg    <= ADMIN_CODE_RST;
            max_fail_reg <= MAX_FAIL_RST;
        end
        else
        begin
            if (we_access)
            begin
                access_reg <= cfg_data;
            end
            if (we_admin)
            begin
                admin_reg <= cfg_data;
            end
            if (we_max)
            begin
                max_fail_reg <= cfg_data[3:0];
            end
        end
    end

    for (genvar s = 0; s < SLOT_MAX; s++)
    begin : g_slot
        if (s < USER_SLOTS)
        begin : g_used
            logic [CODE_W-1:0] user_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    user_reg <= '0;
                end
                else if (we_user[s])
                begin
                    user_reg <= cfg_data;
                end
            end
            assign cfg.user_code[s] = user_reg;
        end
        else
        begin : g_unused
            // zero length: never matches
            assign cfg.user_code[s] = '0;
        end
    end

    assign cfg.access_code  = access_reg;
    assign cfg.admin_code   = admin_reg;
    assign cfg.max_failures = max_fail_reg;

endmodule

>>> design/kcl_core.sv
// ----------------------------------------------------------------------------
// Keypad code lock controller: lock core
// Lock state machine, entry buffer, failure counter and result register.
// One key is processed per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keypad_code_lock_controller_top_defines.svh"

module kcl_core #(
    parameter int MAX_DIGITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic [3:0]     key,
    input  kcl_pkg::cfg_t  cfg,
    output kcl_pkg::res_t  res
);
    import kcl_pkg::*;

    localparam int EW = MAX_DIGITS * 4;

    mode_t               mode_reg;
    mode_t               mode_next;
    logic [EW-1:0]       digits_reg;
    logic [EW-1:0]       digits_next;
    logic [3:0]          len_reg;
    logic [3:0]          len_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [3:0]          fail_reg;
    logic [3:0]          fail_next;
    res_t                res_reg;
    res_t                res_next;

    logic                is_digit;
    logic [31:0]         entry32;
    logic [SLOT_MAX-1:0] match_user;
    logic                any_user;
    logic [1:0]          first_slot;
    logic                match_access;
    logic                match_admin;
    logic                grant;
    logic [3:0]          fail_inc;
    logic                fail_lock;
    logic                room;

    assign is_digit = (key <= KEY_DIGIT_MAX);
    assign entry32  = 32'(digits_reg);
    assign room     = (len_reg < 4'(MAX_DIGITS));

    always_comb
    begin
        for (int s = 0; s < SLOT_MAX; s++)
        begin
            match_user[s] = code_match(entry32, len_reg, ovf_reg, cfg.user_code[s]);
        end
    end

    always_comb
    begin
        first_slot = 2'd0;
        for (int s = SLOT_MAX - 1; s >= 0; s--)
        begin
            if (match_user[s])
            begin
                first_slot = 2'(s);
            end
        end
    end

    assign any_user     = |match_user;
    assign match_access = code_match(entry32, len_reg, ovf_reg, cfg.access_code);
    assign match_admin  = code_match(entry32, len_reg, ovf_reg, cfg.admin_code);
    assign grant        = any_user || match_access;
    assign fail_inc     = (fail_reg == FAIL_SAT) ? fail_reg : fail_reg + 4'd1;
    assign fail_lock    = (fail_inc >= cfg.max_failures);

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        fail_next   = fail_reg;
        if (key == KEY_STAR)
        begin
            digits_next = '0;
            len_next    = 4'd0;
            ovf_next    = 1'b0;
            if (mode_reg != MODE_LOCKED)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            if (key == KEY_A)
            begin
                mode_next   = MODE_ADMIN;
                digits_next = '0;
                len_next    = 4'd0;
                ovf_next    = 1'b0;
            end
            else if (is_digit)
            begin
                mode_next   = MODE_ENTER;
                digits_next = {{(EW-4){1'b0}}, key};
                len_next    = 4'd1;
                ovf_next    = 1'b0;
            end
        end
        else if (is_digit)
        begin
            if (room)
            begin
                digits_next = {digits_reg[EW-5:0], key};
                len_next    = len_reg + 4'd1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (key == KEY_HASH)
        begin
            digits_next = '0;
            len_next    = 4'd0;
            ovf_next    = 1'b0;
            unique case (mode_reg)
                MODE_ENTER:
                begin
                    if (grant)
                    begin
                        fail_next = 4'd0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        fail_next = fail_inc;
                        mode_next = fail_lock ? MODE_LOCKED : MODE_IDLE;
                    end
                end
                MODE_ADMIN:
                begin
                    mode_next = MODE_IDLE;
                end
                MODE_LOCKED:
                begin
                    if (match_admin)
                    begin
                        fail_next = 4'd0;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDLE: ;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res_next                = '0;
        res_next.event_res      = EV_NONE;
        res_next.grant_source   = SRC_NONE;
        res_next.mode_after     = mode_next;
        res_next.digits_entered = len_next;
        res_next.failure_count  = fail_next;
        if (key == KEY_STAR)
        begin
            res_next.event_res = EV_CANCELLED;
        end
        else if (mode_reg == MODE_IDLE)
        begin
            if (key == KEY_A)
            begin
                res_next.event_res = EV_ADMIN_PROMPT;
            end
            else if (is_digit)
            begin
                res_next.event_res = EV_DIGIT;
            end
        end
        else if (is_digit)
        begin
            res_next.event_res = EV_DIGIT;
        end
        else if (key == KEY_HASH)
        begin
            unique case (mode_reg)
                MODE_ENTER:
                begin
                    if (grant)
                    begin
                        res_next.event_res    = EV_GRANTED;
                        res_next.unlock_pulse = 1'b1;
                        res_next.grant_source = any_user ? SRC_USER : SRC_ACCESS;
                        res_next.matched_slot = any_user ? first_slot : 2'd0;
                    end
                    else
                    begin
                        res_next.event_res = fail_lock ? EV_LOCKED : EV_DENIED;
                    end
                end
                MODE_ADMIN:
                begin
                    res_next.event_res = match_admin ? EV_ADMIN_OK : EV_ADMIN_BAD;
                end
                MODE_LOCKED:
                begin
                    res_next.event_res = match_admin ? EV_UNLOCKED : EV_STILL_LOCKED;
                end
                MODE_IDLE: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= '0;
            len_reg    <= 4'd0;
            ovf_reg    <= 1'b0;
            fail_reg   <= 4'd0;
            res_reg    <= '0;
        end
        else if (step_en)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            fail_reg   <= fail_next;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

    `KCL_ASSERT(a_pulse_is_grant, res_reg.unlock_pulse == (res_reg.event_res == EV_GRANTED), "pulse without grant")
    `KCL_ASSERT(a_grant_clears_fail, (res_reg.event_res == EV_GRANTED) |-> (res_reg.failure_count == 4'd0), "grant kept failures")
    `KCL_ASSERT(a_len_bound, len_reg <= 4'(MAX_DIGITS), "entry length beyond limit")
    `KCL_ASSERT(a_lock_sticky, (step_en && mode_reg == MODE_LOCKED) |=> (res_reg.mode_after == MODE_LOCKED || res_reg.event_res == EV_UNLOCKED), "left lockout without admin code")

endmodule
